>>> rtl/bfpd_pkg.sv
package bfpd_pkg;

  localparam logic [31:0] SYNC_WORD = 32'h1DFC_CF1A;

  localparam int NUM_REGS         = 5;
  localparam int MAX_TABLE        = 8;
  localparam int MAX_BLOCK_DATA   = 255;
  localparam int MAX_PACKET_WORDS = 2047;
  localparam int TABLE_ENTRIES_DEF = 5;

  localparam int WORD_W   = 32;
  localparam int ENTRY_W  = 22;
  localparam int ID_W     = 11;
  localparam int LEN_W    = 11;
  localparam int BLOCK_W  = 8;
  localparam int SLOT_W   = 3;
  localparam int SYNC_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_PACKET = 2'd2
  } mode_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } match_t;

  function automatic logic [ID_W-1:0] header_id(input logic [WORD_W-1:0] w);
    header_id = {w[2:0], w[15:8]};
  endfunction

endpackage

>>> rtl/bfpd_match.sv
module bfpd_match #(
  parameter int NUM_ENTRIES = bfpd_pkg::NUM_REGS
) (
  input  bfpd_pkg::entry_t            entries [NUM_ENTRIES],
  input  logic [bfpd_pkg::ID_W-1:0]   id,
  output bfpd_pkg::match_t            result
);
  import bfpd_pkg::*;

  always_comb begin
    logic [LEN_W-1:0] len;
    result = '0;
    // scan downward so the lowest matching slot wins
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      len = entries[i][ID_W +: LEN_W];
      if (len != '0 && entries[i][ID_W-1:0] == id) begin
        result.hit  = 1'b1;
        result.slot = SLOT_W'(i);
        result.len  = (len > LEN_W'(MAX_PACKET_WORDS)) ? LEN_W'(MAX_PACKET_WORDS) : len;
      end
    end
  end

endmodule

>>> rtl/block_framed_packet_deframer.sv
// Block-framed packet deframer. Takes one 32-bit stream word per unstalled cycle; a word
// flagged block_start carries the count of data words that follow (clamped to
// 255, surplus words dropped). Words are hunted for the sync marker 1DFCCF1A;
// the word after it is a header whose 11-bit identifier is matched against up
// to five table entries (cfg index 0..4, bits 10:0 id, bits 21:11 length,
// length zero = unused, lowest entry wins). A matched packet is emitted word
// by word across block boundaries with word_index and last_word; an unmatched
// header yields one event beat and is re-checked as a sync marker. Throughput
// is one word per clock while not stalled; every beat is held in the output register;
// in_stall follows out_stall combinationally only while that register is full.
// Count words and dropped words produce no output beat.
module block_framed_packet_deframer #(
  parameter int TABLE_ENTRIES = bfpd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfpd_pkg::ENTRY_W-1:0]        cfg_data,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bfpd_pkg::WORD_W-1:0]         in_word_in,
  input  logic                                in_block_start,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [bfpd_pkg::WORD_W-1:0]         out_data_word,
  output logic                                out_last_word,
  output logic [bfpd_pkg::LEN_W-1:0]          out_word_index,
  output logic [bfpd_pkg::ID_W-1:0]           out_packet_id,
  output logic [bfpd_pkg::SLOT_W-1:0]         out_table_slot,
  output logic [bfpd_pkg::SYNC_W-1:0]         out_sync_count
);
  import bfpd_pkg::*;

  localparam int NUM_USED = (TABLE_ENTRIES < NUM_REGS) ? TABLE_ENTRIES : NUM_REGS;

  entry_t               table_r [NUM_USED];
  mode_t                mode_r, mode_nxt;
  logic [BLOCK_W-1:0]   block_left_r, block_left_nxt;
  logic [LEN_W-1:0]     packet_left_r, packet_left_nxt;
  logic [LEN_W-1:0]     packet_pos_r, packet_pos_nxt;
  logic [ID_W-1:0]      current_id_r, current_id_nxt;
  logic [SLOT_W-1:0]    current_slot_r, current_slot_nxt;
  logic [SYNC_W-1:0]    syncs_seen_r, syncs_seen_nxt;

  logic                 out_valid_r;
  logic                 out_kind_r, out_kind_nxt;
  logic [WORD_W-1:0]    out_data_r;
  logic                 out_last_r, out_last_nxt;
  logic [LEN_W-1:0]     out_index_r, out_index_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [SYNC_W-1:0]    out_sync_r;

  logic                 accept;
  logic                 res_valid;
  logic                 data_beat;
  logic                 is_sync;
  logic [ID_W-1:0]      hdr_id;
  logic [LEN_W-1:0]     left_dec;
  match_t               match;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign data_beat = !in_block_start && block_left_r != '0;
  assign is_sync   = in_word_in == SYNC_WORD;
  assign hdr_id    = header_id(in_word_in);
  assign left_dec  = packet_left_r - LEN_W'(1);

  bfpd_match #(
    .NUM_ENTRIES (NUM_USED)
  ) u_match (
    .entries (table_r),
    .id      (hdr_id),
    .result  (match)
  );

  // next state
  always_comb begin
    mode_nxt         = mode_r;
    block_left_nxt   = block_left_r;
    packet_left_nxt  = packet_left_r;
    packet_pos_nxt   = packet_pos_r;
    current_id_nxt   = current_id_r;
    current_slot_nxt = current_slot_r;
    syncs_seen_nxt   = syncs_seen_r;
    if (in_block_start) begin
      block_left_nxt = (in_word_in > WORD_W'(MAX_BLOCK_DATA)) ?
                       BLOCK_W'(MAX_BLOCK_DATA) : in_word_in[BLOCK_W-1:0];
    end else if (data_beat) begin
      block_left_nxt = block_left_r - BLOCK_W'(1);
      unique case (mode_r)
        MODE_HEADER: begin
          if (match.hit) begin
            current_id_nxt   = hdr_id;
            current_slot_nxt = match.slot;
            if (match.len == LEN_W'(1)) begin
              mode_nxt        = MODE_HUNT;
              packet_left_nxt = '0;
              packet_pos_nxt  = '0;
            end else begin
              mode_nxt        = MODE_PACKET;
              packet_left_nxt = match.len - LEN_W'(1);
              packet_pos_nxt  = LEN_W'(1);
            end
          end else if (is_sync) begin
            syncs_seen_nxt = syncs_seen_r + SYNC_W'(1);
            packet_pos_nxt = '0;
            mode_nxt       = MODE_HEADER;
          end else begin
            mode_nxt = MODE_HUNT;
          end
        end
        MODE_PACKET: begin
          packet_left_nxt = left_dec;
          packet_pos_nxt  = packet_pos_r + LEN_W'(1);
          if (left_dec == '0) begin
            mode_nxt = MODE_HUNT;
          end
        end
        default: begin
          if (is_sync) begin
            syncs_seen_nxt = syncs_seen_r + SYNC_W'(1);
            packet_pos_nxt = '0;
            mode_nxt       = MODE_HEADER;
          end else begin
            mode_nxt = MODE_HUNT;
          end
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    res_valid     = 1'b0;
    out_kind_nxt  = KIND_PACKET;
    out_last_nxt  = 1'b0;
    out_index_nxt = '0;
    out_id_nxt    = hdr_id;
    out_slot_nxt  = '0;
    if (data_beat) begin
      unique case (mode_r)
        MODE_HEADER: begin
          res_valid = 1'b1;
          if (match.hit) begin
            out_last_nxt = match.len == LEN_W'(1);
            out_slot_nxt = match.slot;
          end else begin
            out_kind_nxt = KIND_EVENT;
          end
        end
        MODE_PACKET: begin
          res_valid     = 1'b1;
          out_last_nxt  = left_dec == '0;
          out_index_nxt = packet_pos_r;
          out_id_nxt    = current_id_r;
          out_slot_nxt  = current_slot_r;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_USED; i++) begin
        table_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NUM_USED; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          table_r[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_HUNT;
      block_left_r   <= '0;
      packet_left_r  <= '0;
      packet_pos_r   <= '0;
      current_id_r   <= '0;
      current_slot_r <= '0;
      syncs_seen_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        mode_r         <= mode_nxt;
        block_left_r   <= block_left_nxt;
        packet_left_r  <= packet_left_nxt;
        packet_pos_r   <= packet_pos_nxt;
        current_id_r   <= current_id_nxt;
        current_slot_r <= current_slot_nxt;
        syncs_seen_r   <= syncs_seen_nxt;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= accept && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind_r  <= out_kind_nxt;
      out_data_r  <= in_word_in;
      out_last_r  <= out_last_nxt;
      out_index_r <= out_index_nxt;
      out_id_r    <= out_id_nxt;
      out_slot_r  <= out_slot_nxt;
      out_sync_r  <= syncs_seen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_word  = out_data_r;
  assign out_last_word  = out_last_r;
  assign out_word_index = out_index_r;
  assign out_packet_id  = out_id_r;
  assign out_table_slot = out_slot_r;
  assign out_sync_count = out_sync_r;

  a_packet_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_PACKET |-> packet_left_r != '0)
    else $error("packet mode with no words left");

  a_count_word_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_block_start |=> !out_valid_r)
    else $error("count word produced a beat");

  a_sync_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && syncs_seen_r != $past(syncs_seen_r) |->
      syncs_seen_r == SYNC_W'($past(syncs_seen_r) + SYNC_W'(1)))
    else $error("sync counter jumped");

  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_EVENT |->
      !out_last_r && out_index_r == '0 && out_slot_r == '0)
    else $error("event beat with packet fields set");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bfpd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
    logic              last;
    logic [LEN_W-1:0]  index;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic [SYNC_W-1:0] syncs;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ENTRY_W-1:0]   cfg_data = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_word_in = '0;
  logic                 in_block_start = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_kind;
  logic [WORD_W-1:0]    out_data_word;
  logic                 out_last_word;
  logic [LEN_W-1:0]     out_word_index;
  logic [ID_W-1:0]      out_packet_id;
  logic [SLOT_W-1:0]    out_table_slot;
  logic [SYNC_W-1:0]    out_sync_count;

  // predictor state
  entry_t            id_table [NUM_REGS];
  mode_t             hunt_mode;
  logic [BLOCK_W-1:0] blk_left;
  logic [LEN_W-1:0]  pkt_left;
  logic [LEN_W-1:0]  pkt_pos;
  logic [ID_W-1:0]   cur_id;
  logic [SLOT_W-1:0] cur_slot;
  logic [SYNC_W-1:0] syncs_found;

  beat_t             deframed_q[$];
  logic [WORD_W-1:0] stream_q[$];
  int                errors = 0;
  int                cycle_count = 0;
  int                stall_left = 0;
  bit                steady_flow = 1'b0;

  always #10 clk = ~clk;

  block_framed_packet_deframer dut (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void expect_beat(logic kind, logic [WORD_W-1:0] w, logic last,
                                      logic [LEN_W-1:0] idx, logic [ID_W-1:0] id,
                                      logic [SLOT_W-1:0] slot);
    deframed_q.push_back('{kind, w, last, idx, id, slot, syncs_found});
  endfunction

  function automatic void hunt_sync(logic [WORD_W-1:0] w);
    if (w == SYNC_WORD) begin
      syncs_found = syncs_found + SYNC_W'(1);
      pkt_pos = '0;
      hunt_mode = MODE_HEADER;
    end else begin
      hunt_mode = MODE_HUNT;
    end
  endfunction

  function automatic void deframe_word(logic [WORD_W-1:0] w, logic bs);
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              last;
    if (bs) begin
      blk_left = (w > MAX_BLOCK_DATA) ? BLOCK_W'(MAX_BLOCK_DATA) : w[BLOCK_W-1:0];
      return;
    end
    if (blk_left == 0) return;
    blk_left = blk_left - BLOCK_W'(1);
    case (hunt_mode)
      MODE_HEADER: begin
        id = {w[2:0], w[15:8]};
        hit = 1'b0;
        len = '0;
        slot = '0;
        // lowest matching entry wins; a length field cannot exceed the packet cap
        for (int i = 0; i < NUM_REGS; i++) begin
          if (!hit && id_table[i][21:11] != 0 && id_table[i][10:0] == id) begin
            hit = 1'b1;
            slot = SLOT_W'(i);
            len = id_table[i][21:11];
          end
        end
        if (hit) begin
          cur_id = id;
          cur_slot = slot;
          if (len == 1) begin
            hunt_mode = MODE_HUNT;
            pkt_left = '0;
            pkt_pos = '0;
            expect_beat(KIND_PACKET, w, 1'b1, '0, id, slot);
          end else begin
            hunt_mode = MODE_PACKET;
            pkt_left = len - LEN_W'(1);
            pkt_pos = LEN_W'(1);
            expect_beat(KIND_PACKET, w, 1'b0, '0, id, slot);
          end
        end else begin
          hunt_sync(w);
          expect_beat(KIND_EVENT, w, 1'b0, '0, id, '0);
        end
      end
      MODE_PACKET: begin
        idx = pkt_pos;
        pkt_left = pkt_left - LEN_W'(1);
        last = (pkt_left == 0);
        pkt_pos = pkt_pos + LEN_W'(1);
        if (last) hunt_mode = MODE_HUNT;
        expect_beat(KIND_PACKET, w, last, idx, cur_id, cur_slot);
      end
      default: hunt_sync(w);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] header_word(logic [ID_W-1:0] id);
    logic [WORD_W-1:0] w;
    w = $urandom;
    w[15:8] = id[7:0];
    w[2:0] = id[10:8];
    return w;
  endfunction

  // valid stays high across back-to-back beats; only lowered before a gap
  task automatic send_word(input logic [WORD_W-1:0] w, input logic bs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word_in <= w;
    in_block_start <= bs;
    do @(posedge clk); while (in_stall);
    deframe_word(w, bs);
  endtask

  task automatic set_table(input entry_t vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      id_table[i] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic refill_stream();
    int r;
    int slot;
    int n;
    logic [ID_W-1:0] rid;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      slot = $urandom_range(0, NUM_REGS - 1);
      n = int'(id_table[slot][21:11]);
      stream_q.push_back(SYNC_WORD);
      stream_q.push_back(header_word(id_table[slot][10:0]));
      for (int k = 1; k < n; k++) stream_q.push_back($urandom);
    end else if (r < 85) begin
      rid = ID_W'($urandom);
      stream_q.push_back(SYNC_WORD);
      if ($urandom_range(0, 3) == 0) stream_q.push_back(SYNC_WORD);
      stream_q.push_back(header_word(rid));
    end else begin
      repeat ($urandom_range(1, 4)) stream_q.push_back($urandom);
    end
  endtask

  task automatic random_table();
    entry_t vals [NUM_REGS];
    logic [ID_W-1:0] id;
    id = ID_W'($urandom);
    for (int i = 0; i < NUM_REGS; i++) begin
      if ($urandom_range(0, 3) != 0) id = ID_W'($urandom);
      vals[i][10:0] = id;
      vals[i][21:11] = ($urandom_range(0, 99) < 15) ? 11'd0 : LEN_W'($urandom_range(1, 8));
    end
    set_table(vals);
  endtask

  task automatic random_phase(input int target);
    int sent;
    int cnt;
    int r;
    logic [WORD_W-1:0] cw;
    sent = 0;
    stream_q.delete();
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 5) cw = '0;
      else if (r < 10) cw = $urandom_range(200, 300);
      else if (r < 13) cw = $urandom;
      else cw = $urandom_range(1, 40);
      send_word(cw, 1'b1);
      cnt = (cw > MAX_BLOCK_DATA) ? MAX_BLOCK_DATA : int'(cw);
      repeat (cnt) begin
        if (stream_q.size() == 0) refill_stream();
        send_word(stream_q.pop_front(), 1'b0);
      end
      sent += cnt;
      // surplus words past the count
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
    end
  endtask

  task automatic test_directed();
    entry_t vals [NUM_REGS];
    vals = '{{11'd3, 11'h123}, {11'd5, 11'h123}, {11'd1, 11'h7FF},
             {11'd0, 11'h055}, {11'd2, 11'h055}};
    set_table(vals);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(SYNC_WORD, 1'b0);
    send_word(header_word(11'h123), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd2, 1'b1);
    send_word(32'h5555_AAAA, 1'b0);
    send_word(32'hAAAA_5555, 1'b0);
    send_word(32'd0, 1'b1);
    send_word(SYNC_WORD, 1'b0);
    send_word(32'd20, 1'b1);
    send_word(SYNC_WORD, 1'b0);
    send_word(header_word(11'h7FF), 1'b0);
    send_word(SYNC_WORD, 1'b0);
    send_word(header_word(11'h055), 1'b0);
    send_word($urandom, 1'b0);
    send_word(SYNC_WORD, 1'b0);
    send_word(header_word(11'h3AA), 1'b0);
    send_word(SYNC_WORD, 1'b0);
    send_word(SYNC_WORD, 1'b0);
    send_word(header_word(11'h123), 1'b0);
    send_word(32'd1, 1'b1);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b0);
    send_word(32'd256, 1'b1);
    send_word($urandom, 1'b0);
    drain();
  endtask

  task automatic test_random_tables();
    repeat (3) begin
      random_table();
      random_phase(90);
      drain();
    end
  endtask

  task automatic test_steady_stream();
    steady_flow = 1'b1;
    random_table();
    random_phase(80);
    drain();
    steady_flow = 1'b0;
  endtask

  // one long packet split over several short blocks
  task automatic test_long_packet();
    entry_t vals [NUM_REGS];
    vals = '{default: {11'd120, 11'h7FF}};
    set_table(vals);
    steady_flow = 1'b1;
    send_word(32'd50, 1'b1);
    send_word(SYNC_WORD, 1'b0);
    send_word(header_word(11'h7FF), 1'b0);
    while (hunt_mode != MODE_HUNT) begin
      if (blk_left == 0) send_word(32'd50, 1'b1);
      else send_word($urandom, 1'b0);
    end
    drain();
    steady_flow = 1'b0;
  endtask

  function automatic void cmp_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_beats
    beat_t b;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual word %h", $time, out_data_word);
        errors++;
      end else begin
        b = deframed_q.pop_front();
        cmp_field("kind", WORD_W'(b.kind), WORD_W'(out_kind));
        cmp_field("data_word", b.word, out_data_word);
        cmp_field("last_word", WORD_W'(b.last), WORD_W'(out_last_word));
        cmp_field("word_index", WORD_W'(b.index), WORD_W'(out_word_index));
        cmp_field("packet_id", WORD_W'(b.id), WORD_W'(out_packet_id));
        cmp_field("table_slot", WORD_W'(b.slot), WORD_W'(out_table_slot));
        cmp_field("sync_count", WORD_W'(b.syncs), WORD_W'(out_sync_count));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0 && !steady_flow) stall_left = pick_gap();
    if (stall_left > 0 && !steady_flow) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    id_table = '{default: '0};
    hunt_mode = MODE_HUNT;
    blk_left = '0;
    pkt_left = '0;
    pkt_pos = '0;
    cur_id = '0;
    cur_slot = '0;
    syncs_found = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_tables();
    test_steady_stream();
    test_long_packet();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
